>>> design/bpc_pkg.sv
// Shared widths, register indexes and the signed truncating shift used by
// the pressure compensation pipeline. No dependencies.
`default_nettype none

package bpc_pkg;

  // datapath widths
  localparam int RawW  = 24;  // raw conversion words
  localparam int CoefW = 16;  // calibration words
  localparam int DtW   = 25;  // temperature difference, signed
  localparam int PrW   = 42;  // dt times a calibration word, signed
  localparam int TempW = 20;  // internal temperature, signed
  localparam int OutTW = 19;  // temperature port
  localparam int OffW  = 40;  // offset, sensitivity and their corrections
  localparam int ProdW = 64;  // raw pressure times sensitivity
  localparam int DiffW = 45;  // scaled product minus offset
  localparam int PresW = 32;  // pressure port
  localparam int SplitW = 20; // low slice of the sensitivity in the wide multiply

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SENS       = 3'd0,
    REG_OFFSET     = 3'd1,
    REG_SENS_TEMP  = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_SLOPE = 3'd5,
    REG_VARIANT    = 3'd6
  } cfg_reg_t;

  // signed divide by 2^k that rounds toward zero
  function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = (64'sd1 <<< k) - 64'sd1;
    if (x < 0) begin
      trunc_shr = (x + bias) >>> k;
    end else begin
      trunc_shr = x >>> k;
    end
  endfunction

endpackage

`default_nettype wire

>>> design/bpc_wide_mul.sv
// Two-stage multiplier: unsigned raw pressure times signed sensitivity,
// split into two narrow partial products. Depends on bpc_pkg.
`default_nettype none

module bpc_wide_mul
  import bpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic [RawW-1:0]         a,
  input  wire logic signed [OffW-1:0]  b,
  output logic signed [ProdW-1:0]      prod
);

  localparam int LoW = RawW + SplitW;
  localparam int HiW = RawW + 1 + OffW - SplitW;

  logic [LoW-1:0]        part_lo;
  logic signed [HiW-1:0] part_hi;

  // partial products on the low and high slices of the sensitivity
  always_ff @(posedge clk) begin
    part_lo <= LoW'(a) * LoW'(b[SplitW-1:0]);
    part_hi <= HiW'($signed({1'b0, a})) * HiW'($signed(b[OffW-1:SplitW]));
  end

  // recombine
  always_ff @(posedge clk) begin
    prod <= (ProdW'(part_hi) <<< SplitW) + $signed({{(ProdW-LoW){1'b0}}, part_lo});
  end

endmodule

`default_nettype wire

>>> design/baro_pressure_compensation_top.sv
// Barometric pressure compensation pipeline, top level.
// Each start is answered by a done strobe when its result is in the output registers.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The wide sensitivity multiply is split over two stages in bpc_wide_mul.
// Reset (rst, synchronous) clears the calibration registers and all valid bits.
// Depends on bpc_pkg and bpc_wide_mul.
`default_nettype none

module baro_pressure_compensation_top
  import bpc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [RawW-1:0]          pressure_raw,
  input  wire logic [RawW-1:0]          temp_raw,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [CoefW-1:0]         cfg_data,
  output logic                          done,
  output logic signed [PresW-1:0]       pressure,
  output logic signed [OutTW-1:0]       temperature
);

  // calibration registers
  logic [CoefW-1:0] sens_coef, offset_coef, sens_temp_coef;
  logic [CoefW-1:0] offset_temp_coef, ref_temp_coef, temp_slope_coef;
  logic             sensor_variant;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coef        <= '0;
      offset_coef      <= '0;
      sens_temp_coef   <= '0;
      offset_temp_coef <= '0;
      ref_temp_coef    <= '0;
      temp_slope_coef  <= '0;
      sensor_variant   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENS:        sens_coef        <= cfg_data;
        REG_OFFSET:      offset_coef      <= cfg_data;
        REG_SENS_TEMP:   sens_temp_coef   <= cfg_data;
        REG_OFFSET_TEMP: offset_temp_coef <= cfg_data;
        REG_REF_TEMP:    ref_temp_coef    <= cfg_data;
        REG_TEMP_SLOPE:  temp_slope_coef  <= cfg_data;
        REG_VARIANT:     sensor_variant   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // valid bits, one per stage
  localparam int Stages = 10;
  logic [Stages-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[Stages-2:0], start && !busy};
    end
  end

  // stage 1: temperature difference
  logic signed [DtW-1:0] dt1;
  logic [RawW-1:0]       d1_1;

  always_ff @(posedge clk) begin
    dt1  <= $signed({1'b0, temp_raw}) - $signed({1'b0, ref_temp_coef, 8'b0});
    d1_1 <= pressure_raw;
  end

  // stage 2: dt times the three temperature coefficients
  logic signed [PrW-1:0] prod_slope2, prod_off2, prod_sens2;
  logic [RawW-1:0]       d1_2;

  always_ff @(posedge clk) begin
    prod_slope2 <= PrW'(dt1) * PrW'($signed({1'b0, temp_slope_coef}));
    prod_off2   <= PrW'(dt1) * PrW'($signed({1'b0, offset_temp_coef}));
    prod_sens2  <= PrW'(dt1) * PrW'($signed({1'b0, sens_temp_coef}));
    d1_2        <= d1_1;
  end

  // stage 3: temperature and first-order offset and sensitivity
  logic signed [63:0]      slope_q, off_q6, off_q7, sens_q7, sens_q8;
  logic signed [OffW-1:0]  off_base, sens_base, off_lin, sens_lin;
  logic signed [TempW-1:0] temp3;
  logic signed [OffW-1:0]  off3, sens3;
  logic [RawW-1:0]         d1_3;

  always_comb begin
    slope_q = trunc_shr(64'(prod_slope2), 23);
    off_q6  = trunc_shr(64'(prod_off2), 6);
    off_q7  = trunc_shr(64'(prod_off2), 7);
    sens_q7 = trunc_shr(64'(prod_sens2), 7);
    sens_q8 = trunc_shr(64'(prod_sens2), 8);
    if (sensor_variant) begin
      off_base  = $signed(OffW'({offset_coef, 17'b0}));
      sens_base = $signed(OffW'({sens_coef, 16'b0}));
      off_lin   = $signed(off_q6[OffW-1:0]);
      sens_lin  = $signed(sens_q7[OffW-1:0]);
    end else begin
      off_base  = $signed(OffW'({offset_coef, 16'b0}));
      sens_base = $signed(OffW'({sens_coef, 15'b0}));
      off_lin   = $signed(off_q7[OffW-1:0]);
      sens_lin  = $signed(sens_q8[OffW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    temp3 <= TempW'(2000) + $signed(slope_q[TempW-1:0]);
    off3  <= off_base + off_lin;
    sens3 <= sens_base + sens_lin;
    d1_3  <= d1_2;
  end

  // stage 4: squares for the two low-temperature bands
  logic signed [TempW-1:0] x_low, x_cold;
  logic signed [OffW-1:0]  sq_low4, sq_cold4, off4, sens4;
  logic signed [TempW-1:0] temp4;
  logic [RawW-1:0]         d1_4;

  assign x_low  = temp3 - TempW'(2000);
  assign x_cold = temp3 + TempW'(1500);

  always_ff @(posedge clk) begin
    sq_low4  <= (temp3 < $signed(TempW'(2000)))  ? OffW'(x_low) * OffW'(x_low)   : '0;
    sq_cold4 <= (temp3 < $signed(-TempW'(1500))) ? OffW'(x_cold) * OffW'(x_cold) : '0;
    off4     <= off3;
    sens4    <= sens3;
    temp4    <= temp3;
    d1_4     <= d1_3;
  end

  // stage 5: second-order corrections (squares are never negative)
  logic signed [OffW-1:0]  off_corr5, sens_corr5, off5, sens5;
  logic signed [TempW-1:0] temp5;
  logic [RawW-1:0]         d1_5;

  always_ff @(posedge clk) begin
    off_corr5  <= ((OffW'(5) * sq_low4) >>> 1) + OffW'(7) * sq_cold4;
    sens_corr5 <= ((OffW'(5) * sq_low4) >>> 2) + ((OffW'(11) * sq_cold4) >>> 1);
    off5       <= off4;
    sens5      <= sens4;
    temp5      <= temp4;
    d1_5       <= d1_4;
  end

  // stage 6: corrected offset and sensitivity
  logic signed [OffW-1:0]  off6, sens6;
  logic signed [TempW-1:0] temp6;
  logic [RawW-1:0]         d1_6;

  always_ff @(posedge clk) begin
    off6  <= off5 - off_corr5;
    sens6 <= sens5 - sens_corr5;
    temp6 <= temp5;
    d1_6  <= d1_5;
  end

  // stages 7 and 8: raw pressure times sensitivity
  logic signed [ProdW-1:0] prod8;
  logic signed [OffW-1:0]  off7, off8;
  logic signed [TempW-1:0] temp7, temp8;

  bpc_wide_mul u_mul (
    .clk  (clk),
    .a    (d1_6),
    .b    (sens6),
    .prod (prod8)
  );

  always_ff @(posedge clk) begin
    off7  <= off6;
    off8  <= off7;
    temp7 <= temp6;
    temp8 <= temp7;
  end

  // stage 9: scale the product and remove the offset
  logic signed [63:0]      scaled;
  logic signed [DiffW-1:0] diff9;
  logic signed [TempW-1:0] temp9;

  assign scaled = trunc_shr(prod8, 21);

  always_ff @(posedge clk) begin
    diff9 <= $signed(scaled[DiffW-1:0]) - DiffW'(off8);
    temp9 <= temp8;
  end

  // stage 10: final scaling, saturation and output register
  logic signed [63:0] pres_q;

  assign pres_q = trunc_shr(64'(diff9), 15);

  always_ff @(posedge clk) begin
    if (pres_q > 64'sd2147483647) begin
      pressure <= $signed({1'b0, {(PresW-1){1'b1}}});
    end else if (pres_q < -64'sd2147483648) begin
      pressure <= $signed({1'b1, {(PresW-1){1'b0}}});
    end else begin
      pressure <= $signed(pres_q[PresW-1:0]);
    end
    temperature <= $signed(temp9[OutTW-1:0]);
  end

  assign done = valid[Stages-1];

endmodule

`default_nettype wire

>>> bench/baro_pressure_compensation_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for baro_pressure_compensation_top: predicts every reading from the
// calibration words and compares it field by field. Depends on bpc_pkg and the block's RTL.

module baro_pressure_compensation_top_tb
  import bpc_pkg::*;
();

  localparam int Latency = 10;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [2:0] NoReg = 3'd7;  // index past the register list, write is dropped
  localparam longint PresMax = 64'sd2147483647;
  localparam longint PresMin = -64'sd2147483648;

  typedef struct packed {
    logic signed [PresW-1:0] pressure;
    logic [OutTW-1:0]        temperature;
  } reading_t;

  // holds the calibration copy and the readings still owed by the block
  class compensation_checker;
    logic [CoefW-1:0] c1, c2, c3, c4, c5, c6;
    logic variant;
    reading_t expected_readings[$];
    int errors;
    int checked;
    int cold;
    int frigid;

    function new();
      c1 = '0; c2 = '0; c3 = '0; c4 = '0; c5 = '0; c6 = '0;
      variant = 1'b0;
      errors = 0; checked = 0; cold = 0; frigid = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [CoefW-1:0] data);
      case (idx)
        REG_SENS:        c1 = data;
        REG_OFFSET:      c2 = data;
        REG_SENS_TEMP:   c3 = data;
        REG_OFFSET_TEMP: c4 = data;
        REG_REF_TEMP:    c5 = data;
        REG_TEMP_SLOPE:  c6 = data;
        REG_VARIANT:     variant = data[0];
        default: ;
      endcase
    endfunction

    // compensated pressure and first-order temperature, exact in 64 bits
    function reading_t compensate(logic [RawW-1:0] d1_raw, logic [RawW-1:0] d2_raw);
      longint d1, d2, k1, k2, k3, k4, k5, k6;
      longint dt, temp, off, sens, off2, sens2, sq, p;
      reading_t r;
      d1 = longint'(d1_raw); d2 = longint'(d2_raw);
      k1 = longint'(c1); k2 = longint'(c2); k3 = longint'(c3);
      k4 = longint'(c4); k5 = longint'(c5); k6 = longint'(c6);
      dt = d2 - k5 * 256;
      temp = 2000 + (dt * k6) / 8388608;
      if (variant) begin
        off  = k2 * 131072 + (k4 * dt) / 64;
        sens = k1 * 65536 + (k3 * dt) / 128;
      end else begin
        off  = k2 * 65536 + (k4 * dt) / 128;
        sens = k1 * 32768 + (k3 * dt) / 256;
      end
      // low temperature corrections, two bands
      off2 = 0;
      sens2 = 0;
      if (temp < 2000) begin
        sq = (temp - 2000) * (temp - 2000);
        off2 = (5 * sq) / 2;
        sens2 = (5 * sq) / 4;
        cold++;
      end
      if (temp < -1500) begin
        sq = (temp + 1500) * (temp + 1500);
        off2 += 7 * sq;
        sens2 += (11 * sq) / 2;
        frigid++;
      end
      off -= off2;
      sens -= sens2;
      p = ((d1 * sens) / 2097152 - off) / 32768;
      if (p > PresMax) p = PresMax;
      if (p < PresMin) p = PresMin;
      r.pressure = p[PresW-1:0];
      r.temperature = temp[OutTW-1:0];
      return r;
    endfunction

    function void note_sample(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
      expected_readings.push_back(compensate(d1, d2));
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic signed [PresW-1:0] p, logic signed [OutTW-1:0] t);
      reading_t want;
      if (expected_readings.size() == 0) begin
        report($sformatf("reading with none pending, pressure %0d temperature %0d", p, t));
      end else begin
        want = expected_readings.pop_front();
        checked++;
        if (p !== want.pressure)
          report($sformatf("pressure %0d, wanted %0d", p, want.pressure));
        if (t !== want.temperature)
          report($sformatf("temperature %0d, wanted %0d", t, $signed(want.temperature)));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [RawW-1:0] pressure_raw;
  logic [RawW-1:0] temp_raw;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [CoefW-1:0] cfg_data;
  logic done;
  logic signed [PresW-1:0] pressure;
  logic signed [OutTW-1:0] temperature;

  compensation_checker comp_check;
  int idle_pct;
  int settings_loaded;
  int unsigned cycles = 0;

  baro_pressure_compensation_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pressure_raw (pressure_raw),
    .temp_raw     (temp_raw),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .pressure     (pressure),
    .temperature  (temperature)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      comp_check.check_result(pressure, temperature);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // one item, with random idle cycles ahead of it
  task automatic send_item(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    pressure_raw <= d1;
    temp_raw <= d2;
    @(posedge clk);
    while (busy) @(posedge clk);
    comp_check.note_sample(d1, d2);
  endtask

  task automatic stop_items();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (comp_check.expected_readings.size() != 0) @(posedge clk);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CoefW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    comp_check.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_calibration(logic [CoefW-1:0] sens, logic [CoefW-1:0] offs,
                                  logic [CoefW-1:0] sens_tc, logic [CoefW-1:0] offs_tc,
                                  logic [CoefW-1:0] ref_t, logic [CoefW-1:0] slope,
                                  logic var_sel);
    logic [CoefW-1:0] junk;
    junk = CoefW'($urandom);
    write_reg(REG_SENS, sens);
    write_reg(REG_OFFSET, offs);
    write_reg(REG_SENS_TEMP, sens_tc);
    write_reg(REG_OFFSET_TEMP, offs_tc);
    write_reg(REG_REF_TEMP, ref_t);
    write_reg(REG_TEMP_SLOPE, slope);
    // upper data bits are don't-care for the variant select
    write_reg(REG_VARIANT, {junk[CoefW-1:1], var_sel});
    settings_loaded++;
  endtask

  // with reference 32768 and slope 32768 each 256 counts of raw temp is 0.01 degC
  task automatic temp_band_items();
    send_item(24'd0, 24'd8388608);        // exactly 20.00 degC
    send_item(24'hFFFFFF, 24'd8388353);   // just under reference, truncates back to 20.00
    send_item(24'd9085466, 24'd8388352);  // 19.99, first low band
    send_item(24'd9085466, 24'd7492608);  // exactly -15.00
    send_item(24'd9085466, 24'd7492352);  // -15.01, second band
    send_item(24'hFFFFFF, 24'd0);         // coldest raw reading
    send_item(24'h800000, 24'hFFFFFF);    // hottest raw reading
    send_item(24'h7FFFFF, 24'd8000000);
  endtask

  function automatic logic [CoefW-1:0] edge_word();
    case ($urandom_range(2))
      0: return '0;
      1: return '1;
      default: return CoefW'($urandom);
    endcase
  endfunction

  // kind 0: sensor-like calibration, 1: fully random, 2: words at the extremes or random
  task automatic random_phase(int kind, int n_items);
    logic [CoefW-1:0] w[6];
    logic [RawW-1:0] d1, d2;
    longint centre;
    for (int k = 0; k < 6; k++) begin
      case (kind)
        0: begin
          case (k)
            0, 1: w[k] = CoefW'($urandom_range(55000, 30000));
            2, 3: w[k] = CoefW'($urandom_range(35000, 15000));
            4: w[k] = CoefW'($urandom_range(40000, 25000));
            default: w[k] = CoefW'($urandom_range(35000, 20000));
          endcase
        end
        1: w[k] = CoefW'($urandom);
        default: w[k] = edge_word();
      endcase
    end
    load_calibration(w[0], w[1], w[2], w[3], w[4], w[5], 1'($urandom_range(1)));
    if ($urandom_range(3) == 0) write_reg(NoReg, CoefW'($urandom));
    for (int n = 0; n < n_items; n++) begin
      d1 = RawW'($urandom);
      if ($urandom_range(1)) begin
        d2 = RawW'($urandom);
      end else begin
        // around the reference so the readings spread over all temperature bands
        centre = longint'(w[4]);
        centre = centre * 256 + longint'($urandom_range(8388607)) - 4194304;
        if (centre < 0) centre = 0;
        if (centre > 16777215) centre = 16777215;
        d2 = centre[RawW-1:0];
      end
      send_item(d1, d2);
    end
    stop_items();
    wait_drained();
  endtask

  initial begin
    comp_check = new();
    rst = 1'b1;
    start = 1'b0;
    pressure_raw = '0;
    temp_raw = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_pct = 31;
    settings_loaded = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // calibration still at reset
    send_item(24'd0, 24'd0);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'hFFFFFF, 24'd0);
    stop_items();
    wait_drained();

    // band edges, both scaling variants
    load_calibration(16'd40000, 16'd40000, 16'd23000, 16'd23000, 16'd32768, 16'd32768, 1'b0);
    temp_band_items();
    stop_items();
    wait_drained();
    write_reg(REG_VARIANT, 16'hFFFF);
    temp_band_items();
    stop_items();
    wait_drained();

    // all words at full scale: lowest temperature
    load_calibration('1, '1, '1, '1, '1, '1, 1'b1);
    send_item(24'hFFFFFF, 24'd0);
    send_item(24'd0, 24'd0);
    stop_items();
    wait_drained();
    // zero reference: highest temperature; out-of-range index must change nothing
    write_reg(REG_REF_TEMP, '0);
    write_reg(NoReg, 16'hFFFF);
    send_item(24'hFFFFFF, 24'hFFFFFF);
    send_item(24'd0, 24'hFFFFFF);
    stop_items();
    wait_drained();

    // random calibrations and readings, idle density changing over the run
    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph < 4) ? 31 : (ph < 8) ? 63 : 0;
      random_phase(ph % 3, 130);
    end

    $display("%0d readings checked over %0d calibration settings, both scaling variants",
             comp_check.checked, settings_loaded);
    $display("%0d predicted below 20.00 degC, %0d below -15.00 degC",
             comp_check.cold, comp_check.frigid);
    if (comp_check.errors == 0 && comp_check.expected_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
